>>> sv/fsa_pkg.sv
// Shared types and constants of the Forth stack ALU.
`timescale 1ns / 1ps
`default_nettype none
package fsa_pkg;
	localparam int CELL_W = 32;
	localparam int OP_W = 5;
	localparam int ST_W = 3;
	localparam int DATA_DEPTH = 64;
	localparam int RETURN_DEPTH = 32;
	localparam int DDEP_W = $clog2(DATA_DEPTH + 1);
	localparam int RDEP_W = $clog2(RETURN_DEPTH + 1);

	typedef logic [CELL_W-1:0] cell_t;

	typedef enum logic [OP_W-1:0] {
		OP_LIT, OP_DUP, OP_SWAP, OP_OVER, OP_ROT, OP_DROP, OP_DROP2, OP_PICK,
		OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT, OP_LT, OP_EQ,
		OP_AND, OP_OR, OP_NOT, OP_TRUE, OP_FALSE, OP_TO_R, OP_FROM_R, OP_DOT
	} op_t;

	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_D_UNDER   = 3'd1;
	localparam logic [ST_W-1:0] ST_D_OVER    = 3'd2;
	localparam logic [ST_W-1:0] ST_DIV_ZERO  = 3'd3;
	localparam logic [ST_W-1:0] ST_R_UNDER   = 3'd4;
	localparam logic [ST_W-1:0] ST_R_OVER    = 3'd5;

	// Forth flags in this machine: zero is true.
	localparam cell_t FLAG_TRUE  = '0;
	localparam cell_t FLAG_FALSE = cell_t'(1);
endpackage
`default_nettype wire

>>> sv/fsa_if.sv
// Valid/ready channels for command words and result words.
`timescale 1ns / 1ps
`default_nettype none
interface fsa_cmd_if;
	import fsa_pkg::*;
	logic valid;
	logic ready;
	logic [OP_W-1:0] op;
	logic signed [CELL_W-1:0] literal;
	modport source (output valid, op, literal, input ready);
	modport sink (input valid, op, literal, output ready);
endinterface

interface fsa_res_if;
	import fsa_pkg::*;
	logic valid;
	logic ready;
	logic signed [CELL_W-1:0] top_value;
	logic [DDEP_W-1:0] data_depth;
	logic [RDEP_W-1:0] return_depth;
	logic printed_valid;
	logic signed [CELL_W-1:0] printed_value;
	logic [ST_W-1:0] status;
	modport source (output valid, top_value, data_depth, return_depth, printed_valid,
		printed_value, status, input ready);
	modport sink (input valid, top_value, data_depth, return_depth, printed_valid,
		printed_value, status, output ready);
endinterface
`default_nettype wire

>>> sv/fsa_div.sv
// Bit-serial signed divider giving truncated quotient and remainder.
`timescale 1ns / 1ps
`default_nettype none
module fsa_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire fsa_pkg::cell_t dividend,
	input  wire fsa_pkg::cell_t divisor,
	output logic done,
	output fsa_pkg::cell_t quotient,
	output fsa_pkg::cell_t remainder
);
	import fsa_pkg::*;
	localparam int CNT_W = $clog2(CELL_W + 1);

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CELL_W:0] rem_q;
	cell_t quo_q, dvs_q;
	logic qneg_q, rneg_q;
	logic [CELL_W:0] trial;
	logic [CELL_W:0] shifted;

	assign shifted = {rem_q[CELL_W-1:0], quo_q[CELL_W-1]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(CELL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[CELL_W-1] ? -dividend : dividend;
			dvs_q <= divisor[CELL_W-1] ? -divisor : divisor;
			qneg_q <= dividend[CELL_W-1] ^ divisor[CELL_W-1];
			rneg_q <= dividend[CELL_W-1];
		end else if (busy_q) begin
			if (!trial[CELL_W]) begin
				rem_q <= trial;
				quo_q <= {quo_q[CELL_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[CELL_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = qneg_q ? -quo_q : quo_q;
	assign remainder = rneg_q ? -rem_q[CELL_W-1:0] : rem_q[CELL_W-1:0];
endmodule
`default_nettype wire

>>> sv/forth_stack_alu_top.sv
// Top level of the Forth stack ALU: sequencer, stack memories and result register.
//
// Each command word is run by a sequencer that reads the top three data cells one per
// cycle from the data stack memory, executes, writes back up to three cells one per
// cycle, then re-reads the new top. Pick adds a read of the picked cell, rotate and swap
// add extra writes, and div and mod wait for the bit-serial divider. The command side is
// ready only while the sequencer is idle. Stack memories need no clearing after reset;
// the depth counters start at zero.
`timescale 1ns / 1ps
`default_nettype none
module forth_stack_alu_top (
	input wire logic clk,
	input wire logic arst_n,
	fsa_cmd_if.sink cmd,
	fsa_res_if.source res
);
	import fsa_pkg::*;
	localparam int DW = $clog2(DATA_DEPTH + 1);
	localparam int AW = $clog2(DATA_DEPTH);
	localparam int RW = $clog2(RETURN_DEPTH + 1);
	localparam int RAW = $clog2(RETURN_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_RB, S_RA, S_RC, S_EXEC, S_DIV, S_PK, S_PKW, S_WR, S_TOP, S_OUT
	} state_t;

	state_t state_q;
	op_t op_q;
	cell_t lit_q, a_q, b_q, rd_q, ret_rd_q;
	logic [DW-1:0] n_q;
	logic [RW-1:0] rc_q;
	logic [AW-1:0] rd_addr;
	cell_t dmem [DATA_DEPTH];
	cell_t rmem [RETURN_DEPTH];

	logic [AW-1:0] waddr_q [3];
	cell_t wdata_q [3];
	logic [1:0] wcnt_q, widx_q;
	logic pv_q;
	cell_t pval_q;
	logic [ST_W-1:0] st_q;
	logic out_valid_q;

	// Execute-stage decode.
	logic [1:0] pops, pushes;
	logic [DW:0] after;
	logic [ST_W-1:0] st_c;
	logic [DW-1:0] newn_c;
	logic [RW-1:0] newrc_c;
	logic [1:0] wcnt_c;
	logic [AW-1:0] waddr_c [3];
	cell_t wdata_c [3];
	logic pv_c, div_c, pick_c, ret_we_c;
	cell_t c_cell, r_c;
	logic [AW-1:0] n0, n1, n2, n3;

	logic div_done;
	cell_t quo, rmd;

	assign c_cell = rd_q;
	assign n0 = AW'(n_q);
	assign n1 = n0 - AW'(1);
	assign n2 = n0 - AW'(2);
	assign n3 = n0 - AW'(3);

	fsa_div u_div (
		.clk(clk), .arst_n(arst_n), .start(state_q == S_EXEC && div_c),
		.dividend(a_q), .divisor(b_q), .done(div_done),
		.quotient(quo), .remainder(rmd)
	);

	always_comb begin
		pops = 2'd0;
		pushes = 2'd0;
		case (op_q)
			OP_LIT, OP_TRUE, OP_FALSE, OP_FROM_R: pushes = 2'd1;
			OP_DUP: begin pops = 2'd1; pushes = 2'd2; end
			OP_SWAP: begin pops = 2'd2; pushes = 2'd2; end
			OP_OVER: begin pops = 2'd2; pushes = 2'd3; end
			OP_ROT: begin pops = 2'd3; pushes = 2'd3; end
			OP_DROP, OP_TO_R, OP_DOT: pops = 2'd1;
			OP_DROP2: pops = 2'd2;
			OP_PICK, OP_NOT: begin pops = 2'd1; pushes = 2'd1; end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT, OP_LT, OP_EQ, OP_AND,
			OP_OR: begin pops = 2'd2; pushes = 2'd1; end
			default: ;
		endcase
	end

	always_comb begin
		after = {1'b0, n_q} - (DW+1)'(pops) + (DW+1)'(pushes);
		if (n_q < DW'(pops))
			st_c = ST_D_UNDER;
		else if (after > (DW+1)'(DATA_DEPTH))
			st_c = ST_D_OVER;
		else
			st_c = ST_OK;
		if (op_q == OP_PICK && st_c == ST_OK &&
				(b_q[CELL_W-1] || b_q >= (CELL_W'(n_q) - CELL_W'(1))))
			st_c = ST_D_UNDER;
		if ((op_q == OP_DIV || op_q == OP_MOD) && st_c == ST_OK && b_q == '0)
			st_c = ST_DIV_ZERO;
		if (op_q == OP_TO_R && st_c == ST_OK && rc_q >= RW'(RETURN_DEPTH))
			st_c = ST_R_OVER;
		if (op_q == OP_FROM_R && rc_q == '0)
			st_c = ST_R_UNDER;

		r_c = '0;
		case (op_q)
			OP_ADD: r_c = a_q + b_q;
			OP_SUB: r_c = a_q - b_q;
			OP_MUL: r_c = a_q * b_q;
			OP_GT: r_c = ($signed(a_q) > $signed(b_q)) ? FLAG_TRUE : FLAG_FALSE;
			OP_LT: r_c = ($signed(a_q) < $signed(b_q)) ? FLAG_TRUE : FLAG_FALSE;
			OP_EQ: r_c = (a_q == b_q) ? FLAG_TRUE : FLAG_FALSE;
			OP_AND: r_c = (a_q == '0 && b_q == '0) ? FLAG_TRUE : FLAG_FALSE;
			OP_OR: r_c = (a_q == '0 || b_q == '0) ? FLAG_TRUE : FLAG_FALSE;
			default: ;
		endcase

		newn_c = n_q;
		newrc_c = rc_q;
		wcnt_c = 2'd0;
		for (int i = 0; i < 3; i++) begin
			waddr_c[i] = n0;
			wdata_c[i] = b_q;
		end
		pv_c = 1'b0;
		div_c = 1'b0;
		pick_c = 1'b0;
		ret_we_c = 1'b0;
		if (st_c == ST_OK) begin
			newn_c = DW'(after);
			case (op_q)
				OP_LIT: begin wcnt_c = 2'd1; wdata_c[0] = lit_q; end
				OP_DUP: wcnt_c = 2'd1;
				OP_SWAP: begin
					wcnt_c = 2'd2;
					waddr_c[0] = n2;
					waddr_c[1] = n1; wdata_c[1] = a_q;
				end
				OP_OVER: begin wcnt_c = 2'd1; wdata_c[0] = a_q; end
				OP_ROT: begin
					wcnt_c = 2'd3;
					waddr_c[0] = n3; wdata_c[0] = a_q;
					waddr_c[1] = n2; wdata_c[1] = b_q;
					waddr_c[2] = n1; wdata_c[2] = c_cell;
				end
				OP_PICK: begin wcnt_c = 2'd1; waddr_c[0] = n1; pick_c = 1'b1; end
				OP_ADD, OP_SUB, OP_MUL, OP_GT, OP_LT, OP_EQ, OP_AND, OP_OR: begin
					wcnt_c = 2'd1; waddr_c[0] = n2; wdata_c[0] = r_c;
				end
				OP_DIV, OP_MOD: begin wcnt_c = 2'd1; waddr_c[0] = n2; div_c = 1'b1; end
				OP_NOT: begin
					wcnt_c = 2'd1; waddr_c[0] = n1;
					wdata_c[0] = (b_q == '0) ? cell_t'(1) : cell_t'(0);
				end
				OP_TRUE: begin wcnt_c = 2'd1; wdata_c[0] = FLAG_TRUE; end
				OP_FALSE: begin wcnt_c = 2'd1; wdata_c[0] = FLAG_FALSE; end
				OP_TO_R: begin ret_we_c = 1'b1; newrc_c = rc_q + RW'(1); end
				OP_FROM_R: begin
					wcnt_c = 2'd1; wdata_c[0] = ret_rd_q; newrc_c = rc_q - RW'(1);
				end
				OP_DOT: pv_c = 1'b1;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (state_q)
			S_RA: rd_addr = n2;
			S_RC: rd_addr = n3;
			S_PK: rd_addr = n2 - AW'(b_q);
			S_TOP, S_OUT: rd_addr = n1;
			default: rd_addr = n1;
		endcase
	end

	// Data stack memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (state_q == S_WR && widx_q != wcnt_q)
			dmem[waddr_q[widx_q]] <= wdata_q[widx_q];
		rd_q <= dmem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && ret_we_c)
			rmem[RAW'(rc_q)] <= b_q;
		ret_rd_q <= rmem[RAW'(rc_q - RW'(1))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			rc_q <= '0;
			out_valid_q <= 1'b0;
			widx_q <= '0;
			wcnt_q <= '0;
		end else begin
			if (res.valid && res.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (cmd.valid) begin
					op_q <= op_t'(cmd.op);
					lit_q <= cmd.literal;
					state_q <= S_RB;
				end
				S_RB: state_q <= S_RA;
				S_RA: begin b_q <= rd_q; state_q <= S_RC; end
				S_RC: begin a_q <= rd_q; state_q <= S_EXEC; end
				S_EXEC: begin
					st_q <= st_c;
					n_q <= newn_c;
					rc_q <= newrc_c;
					pv_q <= pv_c;
					pval_q <= pv_c ? b_q : '0;
					wcnt_q <= wcnt_c;
					widx_q <= '0;
					for (int i = 0; i < 3; i++) begin
						waddr_q[i] <= waddr_c[i];
						wdata_q[i] <= wdata_c[i];
					end
					if (div_c)
						state_q <= S_DIV;
					else if (pick_c)
						state_q <= S_PK;
					else
						state_q <= S_WR;
				end
				S_DIV: if (div_done) begin
					wdata_q[0] <= (op_q == OP_DIV) ? quo : rmd;
					state_q <= S_WR;
				end
				S_PK: state_q <= S_PKW;
				S_PKW: begin wdata_q[0] <= rd_q; state_q <= S_WR; end
				S_WR: begin
					if (widx_q == wcnt_q)
						state_q <= S_TOP;
					else
						widx_q <= widx_q + 2'd1;
				end
				S_TOP: state_q <= S_OUT;
				S_OUT: if (!out_valid_q || res.ready) begin
					out_valid_q <= 1'b1;
					res.top_value <= (n_q != '0) ? rd_q : '0;
					res.data_depth <= DDEP_W'(n_q);
					res.return_depth <= RDEP_W'(rc_q);
					res.printed_valid <= pv_q;
					res.printed_value <= pval_q;
					res.status <= st_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd.ready = (state_q == S_IDLE);
	assign res.valid = out_valid_q;
endmodule
`default_nettype wire

>>> tb/sv/fsa_checker.sv
// Result checker for the Forth stack ALU: tracks both stacks and compares every result word.
`timescale 1ns / 1ps
`default_nettype none
module fsa_checker (
	input wire logic clk,
	input wire logic arst_n,
	fsa_cmd_if cmd,
	fsa_res_if res,
	output int fail_count,
	output int pending_words
);
	import fsa_pkg::*;

	typedef struct packed {
		cell_t top_value;
		logic [DDEP_W-1:0] data_depth;
		logic [RDEP_W-1:0] return_depth;
		logic printed_valid;
		cell_t printed_value;
		logic [ST_W-1:0] status;
	} result_t;

	cell_t data_mem [DATA_DEPTH];
	cell_t ret_mem [RETURN_DEPTH];
	int data_cnt;
	int ret_cnt;
	result_t expected_results [$];

	assign pending_words = expected_results.size();

	function automatic logic [ST_W-1:0] depth_check(int pops, int pushes);
		if (data_cnt < pops)
			return ST_D_UNDER;
		if (data_cnt - pops + pushes > DATA_DEPTH)
			return ST_D_OVER;
		return ST_OK;
	endfunction

	// Executes one command word on the shadow stacks and returns the result it must give.
	function automatic result_t execute_word(logic [OP_W-1:0] op, cell_t lit);
		result_t r;
		int n;
		cell_t a, b, v;
		logic [ST_W-1:0] st;
		n = data_cnt;
		r = '0;
		st = ST_OK;
		a = (n >= 2) ? data_mem[n-2] : '0;
		b = (n >= 1) ? data_mem[n-1] : '0;
		case (op)
			OP_LIT, OP_TRUE, OP_FALSE: begin
				st = depth_check(0, 1);
				if (st == ST_OK) begin
					data_mem[n] = (op == OP_LIT) ? lit : (op == OP_TRUE) ? FLAG_TRUE : FLAG_FALSE;
					data_cnt = n + 1;
				end
			end
			OP_DUP: begin
				st = depth_check(1, 2);
				if (st == ST_OK) begin
					data_mem[n] = b;
					data_cnt = n + 1;
				end
			end
			OP_SWAP: begin
				st = depth_check(2, 2);
				if (st == ST_OK) begin
					data_mem[n-2] = b;
					data_mem[n-1] = a;
				end
			end
			OP_OVER: begin
				st = depth_check(2, 3);
				if (st == ST_OK) begin
					data_mem[n] = a;
					data_cnt = n + 1;
				end
			end
			OP_ROT: begin
				st = depth_check(3, 3);
				if (st == ST_OK) begin
					v = data_mem[n-3];
					data_mem[n-3] = a;
					data_mem[n-2] = b;
					data_mem[n-1] = v;
				end
			end
			OP_DROP, OP_DOT: begin
				st = depth_check(1, 0);
				if (st == ST_OK) begin
					data_cnt = n - 1;
					if (op == OP_DOT) begin
						r.printed_valid = 1'b1;
						r.printed_value = b;
					end
				end
			end
			OP_DROP2: begin
				st = depth_check(2, 0);
				if (st == ST_OK)
					data_cnt = n - 2;
			end
			OP_PICK: begin
				st = depth_check(1, 1);
				if (st == ST_OK) begin
					if (b[CELL_W-1] || b >= cell_t'(n - 1))
						st = ST_D_UNDER;
					else
						data_mem[n-1] = data_mem[n-2-int'(b)];
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT, OP_LT, OP_EQ, OP_AND, OP_OR: begin
				st = depth_check(2, 1);
				if (st == ST_OK) begin
					case (op)
						OP_ADD: v = a + b;
						OP_SUB: v = a - b;
						OP_MUL: v = a * b;
						OP_DIV, OP_MOD: begin
							if (b == '0)
								st = ST_DIV_ZERO;
							else if (a == {1'b1, {(CELL_W-1){1'b0}}} && b == '1)
								v = (op == OP_DIV) ? a : '0;
							else
								v = (op == OP_DIV) ? cell_t'($signed(a) / $signed(b))
									: cell_t'($signed(a) % $signed(b));
						end
						OP_GT: v = ($signed(a) > $signed(b)) ? FLAG_TRUE : FLAG_FALSE;
						OP_LT: v = ($signed(a) < $signed(b)) ? FLAG_TRUE : FLAG_FALSE;
						OP_EQ: v = (a == b) ? FLAG_TRUE : FLAG_FALSE;
						OP_AND: v = (a == '0 && b == '0) ? FLAG_TRUE : FLAG_FALSE;
						default: v = (a == '0 || b == '0) ? FLAG_TRUE : FLAG_FALSE;
					endcase
					if (st == ST_OK) begin
						data_mem[n-2] = v;
						data_cnt = n - 1;
					end
				end
			end
			OP_NOT: begin
				st = depth_check(1, 1);
				if (st == ST_OK)
					data_mem[n-1] = (b == '0) ? cell_t'(1) : '0;
			end
			OP_TO_R: begin
				st = depth_check(1, 0);
				if (st == ST_OK && ret_cnt >= RETURN_DEPTH)
					st = ST_R_OVER;
				if (st == ST_OK) begin
					ret_mem[ret_cnt] = b;
					ret_cnt++;
					data_cnt = n - 1;
				end
			end
			OP_FROM_R: begin
				st = (ret_cnt == 0) ? ST_R_UNDER : depth_check(0, 1);
				if (st == ST_OK) begin
					ret_cnt--;
					data_mem[n] = ret_mem[ret_cnt];
					data_cnt = n + 1;
				end
			end
			default: ;
		endcase
		r.top_value = (data_cnt > 0) ? data_mem[data_cnt-1] : '0;
		r.data_depth = DDEP_W'(data_cnt);
		r.return_depth = RDEP_W'(ret_cnt);
		r.status = st;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			data_cnt = 0;
			ret_cnt = 0;
			fail_count = 0;
			expected_results.delete();
		end else begin
			// The result is popped before the new command is pushed; a word can never
			// complete in the cycle it is accepted, so the order is safe.
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result word with nothing expected", $realtime);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (res.top_value !== want.top_value)
						report_mismatch("top_value", res.top_value, want.top_value);
					if (res.data_depth !== want.data_depth)
						report_mismatch("data_depth", res.data_depth, want.data_depth);
					if (res.return_depth !== want.return_depth)
						report_mismatch("return_depth", res.return_depth, want.return_depth);
					if (res.printed_valid !== want.printed_valid)
						report_mismatch("printed_valid", res.printed_valid, want.printed_valid);
					if (res.printed_value !== want.printed_value)
						report_mismatch("printed_value", res.printed_value, want.printed_value);
					if (res.status !== want.status)
						report_mismatch("status", res.status, want.status);
				end
			end
			if (cmd.valid && cmd.ready)
				expected_results.push_back(execute_word(cmd.op, cmd.literal));
		end
	end
endmodule
`default_nettype wire

>>> tb/sv/forth_stack_alu_top_tb.sv
// Testbench top for the Forth stack ALU: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none
module forth_stack_alu_top_tb;
	import fsa_pkg::*;

	localparam int RANDOM_WORDS = 1040;
	// Limit well above the slowest words and the random idle gaps on both sides.
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending_words;
	int cycle_count;
	bit hold_results;
	int depth_guess;

	fsa_cmd_if cmd ();
	fsa_res_if res ();

	forth_stack_alu_top dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res));

	fsa_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res),
		.fail_count(fail_count), .pending_words(pending_words));

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		cmd.valid = 1'b0;
		cmd.op = '0;
		cmd.literal = '0;
		res.ready = 1'b0;
		hold_results = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("forth_stack_alu_top regression: fail");
			$finish;
		end
	end
	initial cycle_count = 0;

	// Result side: random stalls per word, or a long hold-off when asked.
	always begin
		int gap;
		@(posedge clk);
		if (arst_n) begin
			if (hold_results) begin
				res.ready <= 1'b0;
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				if (gap > 0) begin
					res.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				res.ready <= 1'b1;
				do @(posedge clk); while (!(res.valid && res.ready));
				res.ready <= 1'b0;
			end
		end
	end

	task automatic send_word(op_t op, cell_t lit, int gap);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.op <= op;
		cmd.literal <= lit;
		do @(posedge clk); while (!cmd.ready);
		// Track depth loosely so the random part stays in the interesting range.
		case (op)
			OP_LIT, OP_DUP, OP_OVER, OP_TRUE, OP_FALSE, OP_FROM_R: depth_guess++;
			OP_DROP, OP_DOT, OP_TO_R, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
			OP_GT, OP_LT, OP_EQ, OP_AND, OP_OR: depth_guess--;
			OP_DROP2: depth_guess -= 2;
			default: ;
		endcase
		if (depth_guess < 0)
			depth_guess = 0;
	endtask

	function automatic cell_t random_cell();
		case ($urandom_range(0, 5))
			0: return cell_t'($urandom_range(0, 4));
			1: return '1;
			2: return {1'b1, {(CELL_W-1){1'b0}}};
			3: return {1'b0, {(CELL_W-1){1'b1}}};
			4: return -cell_t'($urandom_range(1, 9));
			default: return $urandom;
		endcase
	endfunction

	function automatic op_t random_op();
		int pick;
		pick = $urandom_range(0, 99);
		if (depth_guess < 8 && pick < 35)
			return OP_LIT;
		if (depth_guess > 56 && pick < 35)
			return op_t'($urandom_range(OP_ADD, OP_OR));
		return op_t'($urandom_range(0, 23));
	endfunction

	// The first edge lets the checker record the word accepted just before.
	task automatic wait_drained();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
	endtask

	initial begin
		int gap;
		op_t op;
		cell_t lit;
		depth_guess = 0;
		@(posedge arst_n);
		@(posedge clk);
		// Directed: underflow on an empty machine, return underflow, then divide, stack, pick, return and print words.
		send_word(OP_DROP, '0, 0);
		send_word(OP_FROM_R, '0, 0);
		send_word(OP_ADD, '0, 0);
		send_word(OP_LIT, {1'b1, {(CELL_W-1){1'b0}}}, 0);
		send_word(OP_LIT, '1, 0);
		send_word(OP_DIV, '0, 0);
		send_word(OP_LIT, {1'b1, {(CELL_W-1){1'b0}}}, 1);
		send_word(OP_LIT, '1, 0);
		send_word(OP_MOD, '0, 0);
		send_word(OP_TRUE, '0, 0);
		send_word(OP_DIV, '0, 0);
		send_word(OP_LIT, {1'b0, {(CELL_W-1){1'b1}}}, 0);
		send_word(OP_OVER, '0, 0);
		send_word(OP_ROT, '0, 2);
		send_word(OP_SWAP, '0, 0);
		send_word(OP_LIT, cell_t'(1), 0);
		send_word(OP_PICK, '0, 0);
		send_word(OP_LIT, cell_t'(9), 0);
		send_word(OP_PICK, '0, 0);
		send_word(OP_NOT, '0, 0);
		send_word(OP_TO_R, '0, 0);
		send_word(OP_FROM_R, '0, 0);
		send_word(OP_DOT, '0, 0);
		send_word(OP_FALSE, '0, 0);
		send_word(OP_DROP2, '0, 0);
		wait_drained();

		// Fill the return stack to overflow, then empty it again.
		repeat (RETURN_DEPTH + 1) begin
			send_word(OP_LIT, $urandom, 0);
			send_word(OP_TO_R, '0, 0);
		end
		repeat (RETURN_DEPTH + 1) send_word(OP_FROM_R, '0, 0);

		// Long result hold-off while commands keep coming, pushing the data stack to overflow.
		hold_results = 1'b1;
		fork
			begin
				repeat (DATA_DEPTH + 2) send_word(OP_LIT, random_cell(), 0);
			end
			begin
				repeat (300) @(posedge clk);
				hold_results = 1'b0;
			end
		join
		wait_drained();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			op = random_op();
			lit = random_cell();
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (op == OP_PICK && $urandom_range(0, 1) == 0) begin
				send_word(OP_LIT, cell_t'($urandom_range(0, 5)), gap);
				gap = 0;
			end
			send_word(op, lit, gap);
			if (i == RANDOM_WORDS / 2)
				wait_drained();
		end
		wait_drained();
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending_words == 0)
			$display("forth_stack_alu_top regression: pass");
		else
			$display("forth_stack_alu_top regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

>>> forth_stack_alu_top.f
sv/fsa_pkg.sv
sv/fsa_if.sv
sv/fsa_div.sv
sv/forth_stack_alu_top.sv
tb/sv/fsa_checker.sv
tb/sv/forth_stack_alu_top_tb.sv
